// ===== rtl/bnfa_pkg.sv =====
// Shared types, sizes and helper functions for the bitmap next-fit allocator.
// No dependencies; the interfaces, the top level and the testbench import this package.
`default_nettype none

package bnfa_pkg;

    localparam int MAX_SLOTS  = 4096;
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = $clog2(WORD_COUNT);
    localparam int MODE_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]     t_count;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 3'd0,
        MODE_FREE  = 3'd1,
        MODE_QUERY = 3'd2,
        MODE_SEEK  = 3'd3,
        MODE_CLEAR = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_NO_FREE    = 2'd1,
        ST_RANGE      = 2'd2,
        ST_DOUBLE_FREE = 2'd3
    } t_status;

    // Register index, taken from paddr above the byte offset.
    localparam logic REG_SIZE_IN_BITS = 1'b0;

    // Size in use, clipped to the capacity of the store.
    function automatic t_count eff_of(input t_count size);
        eff_of = (size > t_count'(MAX_SLOTS)) ? t_count'(MAX_SLOTS) : size;
    endfunction

    // Position of the lowest set bit of a word (zero when none is set).
    function automatic logic [BIT_W-1:0] lowest_set(input t_word v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = BIT_W'(i);
            end
        end
        lowest_set = pos;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bnfa_intf.sv =====
// Request and response channel interfaces of the bitmap next-fit allocator.
// Depends on bnfa_pkg for field widths.
`default_nettype none

interface bnfa_req_if;
    import bnfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [SLOT_W-1:0]    slot_index;

    modport source (output valid, mode, slot_index, input ready);
    modport sink   (input valid, mode, slot_index, output ready);
endinterface

interface bnfa_rsp_if;
    import bnfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    granted_index;
    logic                 slot_free;
    logic [CNT_W-1:0]     free_count;

    modport source (output valid, status, granted_index, slot_free, free_count, input ready);
    modport sink   (input valid, status, granted_index, slot_free, free_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/bnfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module bnfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_next_fit_allocator.sv =====
// Top level of the bitmap next-fit allocator: control, scan logic and result register.
// Depends on bnfa_pkg, the channel interfaces in bnfa_intf.sv and bnfa_ram.
//
// One used bit per slot lives in a 64 x 64-bit RAM with a registered read.
// Each item is handled alone: the item is accepted and its first word is read,
// then the words are examined in turn. Free, query, clear and a seek or allocate
// that finds room in its first word finish on that word; a scanning allocate or
// seek goes on to each further word, up to a scan over the whole store, and the
// RAM delivers one word per cycle. An item finishes only once the output register
// is free. The result sits in that register, so the next item is taken while it waits.
// Per-word valid flip-flops make reset, clear and a size write take effect at
// once, with no clearing pass. Writing size_in_bits empties the store.
`default_nettype none

module bitmap_next_fit_allocator (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    bnfa_req_if.sink                    i_req,
    bnfa_rsp_if.source                  o_rsp,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [bnfa_pkg::APB_AW-1:0] paddr,
    input  wire logic [bnfa_pkg::APB_DW-1:0] pwdata,
    output logic      [bnfa_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import bnfa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state               r_state;
    logic [MODE_W-1:0]    r_mode;
    logic [SLOT_W-1:0]    r_idx;
    t_count               r_start;
    logic [WADDR_W-1:0]   r_word;
    logic                 r_rd_ok;
    t_count               r_hint;
    t_count               r_free;
    t_count               r_size;
    logic [WORD_COUNT-1:0] r_wvalid;

    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_out_status;
    logic [SLOT_W-1:0]    r_out_granted;
    logic                 r_out_sfree;
    t_count               r_out_count;

    t_count               eff;
    logic [WADDR_W:0]     eff_w;
    logic [BIT_W-1:0]     eff_b;
    logic [WADDR_W:0]     eff_words;
    logic [CNT_W-1:0]     eff_round;
    t_word                ram_rdata;
    t_word                word_data;
    t_word                lo_mask;
    t_word                hi_mask;
    t_word                cand;
    logic                 found;
    logic [BIT_W-1:0]     fbit;
    logic [SLOT_W-1:0]    found_slot;
    logic                 is_scan_op;
    logic                 scan_ok;
    logic                 more;
    logic                 scan_more;
    logic                 out_free;
    logic                 done;
    logic                 hit;
    logic                 idx_ok;
    logic                 bit_used;
    logic                 accept;
    logic                 cfg_we;
    t_count               acc_start;

    logic                 ram_we;
    t_word                ram_wdata;
    logic                 ram_re;
    logic [WADDR_W-1:0]   ram_raddr;

    t_count               n_hint;
    t_count               n_free;
    logic                 n_clear;
    logic [STATUS_W-1:0]  n_status;
    logic [SLOT_W-1:0]    n_granted;
    logic                 n_sfree;

    // ---------------------------------------------------------------- decode
    assign eff       = eff_of(r_size);
    assign eff_w     = eff[CNT_W-1:BIT_W];
    assign eff_b     = eff[BIT_W-1:0];
    assign eff_round = eff + t_count'(WORD_BITS - 1);
    assign eff_words = eff_round[CNT_W-1:BIT_W];

    assign accept    = i_req.valid && i_req.ready;
    assign acc_start = (t_mode'(i_req.mode) == MODE_ALLOC) ? r_hint
                                                          : {1'b0, i_req.slot_index};

    assign word_data = r_rd_ok ? ram_rdata : '0;

    // Candidate bits: clear, not below the start slot and below the size in use.
    assign lo_mask = (r_word == r_start[SLOT_W-1:BIT_W]) ?
                     ~((t_word'(1) << r_start[BIT_W-1:0]) - t_word'(1)) : '1;
    always_comb begin
        priority if ({1'b0, r_word} < eff_w) begin
            hi_mask = '1;
        end else if ({1'b0, r_word} == eff_w) begin
            hi_mask = (t_word'(1) << eff_b) - t_word'(1);
        end else begin
            hi_mask = '0;
        end
    end

    assign cand       = ~word_data & lo_mask & hi_mask;
    assign found      = |cand;
    assign fbit       = lowest_set(cand);
    assign found_slot = {r_word, fbit};

    assign is_scan_op = (t_mode'(r_mode) == MODE_ALLOC) || (t_mode'(r_mode) == MODE_SEEK);
    assign scan_ok    = (r_free != '0) && (r_start < eff);
    assign hit        = scan_ok && found;
    assign more       = ({1'b0, r_word} + (WADDR_W + 1)'(1)) < eff_words;
    assign scan_more  = (r_state == S_SCAN) && is_scan_op && scan_ok && !found && more;
    assign out_free   = !r_out_valid || o_rsp.ready;
    assign done       = (r_state == S_SCAN) && !scan_more && out_free;

    assign idx_ok     = {1'b0, r_idx} < eff;
    assign bit_used   = word_data[r_idx[BIT_W-1:0]];

    // ------------------------------------------------------------ RAM access
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = r_word + WADDR_W'(1);
        if (accept) begin
            ram_re    = 1'b1;
            ram_raddr = acc_start[SLOT_W-1:BIT_W];
        end else if (scan_more) begin
            ram_re    = 1'b1;
        end
    end

    bnfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------- result of one item
    always_comb begin
        n_hint    = r_hint;
        n_free    = r_free;
        n_clear   = 1'b0;
        n_status  = ST_OK;
        n_granted = '0;
        n_sfree   = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = word_data;
        unique case (t_mode'(r_mode))
            MODE_ALLOC: begin
                if (hit) begin
                    ram_we    = done;
                    ram_wdata = word_data | (t_word'(1) << fbit);
                    n_free    = r_free - t_count'(1);
                    n_hint    = {1'b0, found_slot} + t_count'(1);
                    n_granted = found_slot;
                end else begin
                    n_status  = ST_NO_FREE;
                end
            end
            MODE_FREE: begin
                if (!idx_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    if ({1'b0, r_idx} < r_hint) begin
                        n_hint = {1'b0, r_idx};
                    end
                    if (bit_used) begin
                        ram_we    = done;
                        ram_wdata = word_data & ~(t_word'(1) << r_idx[BIT_W-1:0]);
                        n_free    = r_free + t_count'(1);
                    end else begin
                        n_status  = ST_DOUBLE_FREE;
                    end
                end
            end
            MODE_QUERY: begin
                if (!idx_ok) begin
                    n_status = ST_RANGE;
                end else begin
                    n_sfree  = !bit_used;
                end
            end
            MODE_SEEK: begin
                n_hint = hit ? {1'b0, found_slot} : {1'b0, r_idx};
            end
            MODE_CLEAR: begin
                n_clear = 1'b1;
                n_hint  = '0;
                n_free  = eff;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------ config register
    assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1] == REG_SIZE_IN_BITS);
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1] == REG_SIZE_IN_BITS) ?
                    {{(APB_DW - CNT_W){1'b0}}, r_size} : '0;

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= t_count'(MAX_SLOTS);
            r_free      <= t_count'(MAX_SLOTS);
            r_hint      <= '0;
            r_wvalid    <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                r_size   <= pwdata[CNT_W-1:0];
                r_free   <= eff_of(pwdata[CNT_W-1:0]);
                r_hint   <= '0;
                r_wvalid <= '0;
            end

            if (ram_re) begin
                r_rd_ok <= r_wvalid[ram_raddr];
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (done) begin
                        r_state <= S_IDLE;
                        r_hint  <= n_hint;
                        r_free  <= n_free;
                        if (n_clear) begin
                            r_wvalid <= '0;
                        end else if (ram_we) begin
                            r_wvalid[r_word] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_req.mode;
            r_idx   <= i_req.slot_index;
            r_start <= acc_start;
            r_word  <= acc_start[SLOT_W-1:BIT_W];
        end else if (scan_more) begin
            r_word  <= r_word + WADDR_W'(1);
        end
        if (done) begin
            r_out_status  <= n_status;
            r_out_granted <= n_granted;
            r_out_sfree   <= n_sfree;
            r_out_count   <= n_free;
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.granted_index = r_out_granted;
    assign o_rsp.slot_free     = r_out_sfree;
    assign o_rsp.free_count    = r_out_count;

`ifndef NO_ASSERTIONS
    // The free count never exceeds the size in use.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= eff)
        else $error("free count above size in use");

    // The store is written back only when an item finishes, and the block is idle after.
    a_write_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> done ##1 (r_state == S_IDLE))
        else $error("RAM write outside item completion");

    // A continuing scan steps exactly one word forward.
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_more |=> (r_word == $past(r_word) + WADDR_W'(1)) && (r_state == S_SCAN))
        else $error("scan did not advance by one word");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_out_valid) |-> o_rsp.ready)
        else $error("result register overwritten");

    // A successful allocate hands out a slot below the size in use.
    a_grant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && ram_we && (t_mode'(r_mode) == MODE_ALLOC)) |-> ({1'b0, found_slot} < eff))
        else $error("granted slot out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/bitmap_next_fit_allocator_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap next-fit allocator: directed table, then random phases.
// Depends on bnfa_pkg, the channel interfaces in bnfa_intf.sv and bitmap_next_fit_allocator.

module bitmap_next_fit_allocator_test;
    import bnfa_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 80;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_PHASE   = 6;
    localparam int MAX_PRINTS   = 40;

    // Codes that the block accepts but does nothing with.
    localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam logic [APB_AW-1:0] SIZE_ADDR = {REG_SIZE_IN_BITS, 2'b00};

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   granted;
        logic                slot_free;
        logic [CNT_W-1:0]    free_count;
    } t_reply;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_KNOWN,
        ROW_SIZE
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [MODE_W-1:0]  mode;
        logic [SLOT_W-1:0]  slot;
        logic [APB_DW-1:0]  size;
        t_reply             want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    wire  [APB_DW-1:0]  prdata;
    wire                pready;

    bnfa_req_if req_ch ();
    bnfa_rsp_if rsp_ch ();

    bitmap_next_fit_allocator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the allocator state.
    logic [MAX_SLOTS-1:0] taken_map;
    logic [CNT_W-1:0]     hint_pos;
    logic [CNT_W-1:0]     free_left;
    logic [CNT_W-1:0]     size_reg;
    logic [SLOT_W-1:0]    held_slots[$];

    t_reply replies_due[$];
    int     mismatches   = 0;
    int     snd_idle_pct = 0;
    int     rcv_idle_pct = 0;
    int     hold_asks    = 0;
    int     quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int clipped_size();
        return (size_reg > CNT_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(size_reg);
    endfunction

    function automatic void clear_store();
        taken_map = '0;
        hint_pos  = '0;
        free_left = CNT_W'(clipped_size());
        held_slots.delete();
    endfunction

    // Lowest clear slot in [from, size), or -1 when there is none.
    function automatic int first_clear_from(input int from);
        for (int s = from; s < clipped_size(); s++) begin
            if (!taken_map[s]) begin
                return s;
            end
        end
        return -1;
    endfunction

    function automatic t_reply predict_reply(input logic [MODE_W-1:0] mode,
                                             input logic [SLOT_W-1:0] slot);
        t_reply r;
        int     span;
        int     hit;
        r = '0;
        span = clipped_size();
        case (mode)
            MODE_ALLOC: begin
                hit = (free_left == '0) ? -1 : first_clear_from(int'(hint_pos));
                if (hit < 0) begin
                    r.status = ST_NO_FREE;
                end else begin
                    taken_map[hit] = 1'b1;
                    free_left = free_left - 1'b1;
                    hint_pos = CNT_W'(hit + 1);
                    r.granted = SLOT_W'(hit);
                    held_slots.push_back(SLOT_W'(hit));
                end
            end
            MODE_FREE: begin
                if (int'(slot) >= span) begin
                    r.status = ST_RANGE;
                end else begin
                    // The hint drops even when the free turns out to be a double free.
                    if (CNT_W'(slot) < hint_pos) begin
                        hint_pos = CNT_W'(slot);
                    end
                    if (taken_map[slot]) begin
                        taken_map[slot] = 1'b0;
                        free_left = free_left + 1'b1;
                    end else begin
                        r.status = ST_DOUBLE_FREE;
                    end
                end
            end
            MODE_QUERY: begin
                if (int'(slot) >= span) begin
                    r.status = ST_RANGE;
                end else begin
                    r.slot_free = !taken_map[slot];
                end
            end
            MODE_SEEK: begin
                hit = (free_left == '0) ? -1 : first_clear_from(int'(slot));
                hint_pos = (hit < 0) ? CNT_W'(slot) : CNT_W'(hit);
            end
            MODE_CLEAR: begin
                clear_store();
            end
            default: begin
            end
        endcase
        r.free_count = free_left;
        return r;
    endfunction

    function automatic t_row known_row(input logic [MODE_W-1:0] mode,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [STATUS_W-1:0] status,
                                       input logic [SLOT_W-1:0] granted,
                                       input logic slot_free,
                                       input logic [CNT_W-1:0] free_count);
        t_row r;
        r = '0;
        r.kind = ROW_KNOWN;
        r.mode = mode;
        r.slot = slot;
        r.want.status = status;
        r.want.granted = granted;
        r.want.slot_free = slot_free;
        r.want.free_count = free_count;
        return r;
    endfunction

    function automatic t_row predicted_row(input logic [MODE_W-1:0] mode,
                                           input logic [SLOT_W-1:0] slot);
        t_row r;
        r = '0;
        r.kind = ROW_PREDICT;
        r.mode = mode;
        r.slot = slot;
        return r;
    endfunction

    function automatic t_row size_row(input logic [APB_DW-1:0] value);
        t_row r;
        r = '0;
        r.kind = ROW_SIZE;
        r.size = value;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [SLOT_W-1:0] slot,
                                input bit typed, input t_reply want);
        t_reply guess;
        if ($urandom_range(99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.slot_index <= slot;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        guess = predict_reply(mode, slot);
        replies_due.push_back(typed ? want : guess);
    endtask

    // Every item yields a result, so the block is idle once all results are in.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        size_reg = value[CNT_W-1:0];
        clear_store();
    endtask

    task automatic pick_request(output logic [MODE_W-1:0] mode,
                                output logic [SLOT_W-1:0] slot);
        int roll;
        int k;
        roll = $urandom_range(99);
        if ($urandom_range(99) < 80 && clipped_size() > 0) begin
            slot = SLOT_W'($urandom_range(clipped_size() - 1));
        end else begin
            slot = SLOT_W'($urandom());
        end
        if (roll < 45) begin
            mode = MODE_ALLOC;
        end else if (roll < 70) begin
            mode = MODE_FREE;
            // Mostly give back a slot that is actually held.
            if (held_slots.size() != 0 && $urandom_range(99) < 75) begin
                k = $urandom_range(held_slots.size() - 1);
                slot = held_slots[k];
                held_slots.delete(k);
            end
        end else if (roll < 82) begin
            mode = MODE_QUERY;
        end else if (roll < 93) begin
            mode = MODE_SEEK;
        end else if (roll < 95) begin
            mode = MODE_CLEAR;
        end else begin
            mode = MODE_W'($urandom_range(MODE_SPARE7, MODE_SPARE5));
        end
    endtask

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        int stall_left;
        int served;
        stall_left = 0;
        served = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != served) begin
                served = hold_asks;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (replies_due.size() == 0) begin
                report_mismatch("result with none outstanding", rsp_ch.status, 0);
            end else begin
                want = replies_due.pop_front();
                if (rsp_ch.status !== want.status) begin
                    report_mismatch("status", rsp_ch.status, want.status);
                end
                if (rsp_ch.granted_index !== want.granted) begin
                    report_mismatch("granted_index", rsp_ch.granted_index, want.granted);
                end
                if (rsp_ch.slot_free !== want.slot_free) begin
                    report_mismatch("slot_free", rsp_ch.slot_free, want.slot_free);
                end
                if (rsp_ch.free_count !== want.free_count) begin
                    report_mismatch("free_count", rsp_ch.free_count, want.free_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row              plan[$];
        t_row              row;
        logic [APB_DW-1:0] phase_size[PHASES];
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;

        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = '0;
        req_ch.slot_index = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        size_reg          = CNT_W'(MAX_SLOTS);
        clear_store();

        // Default size: edges of the store, hint movement, double free, no wrap.
        plan.push_back(known_row(MODE_QUERY, 12'd0, ST_OK, 12'd0, 1'b1, CNT_W'(MAX_SLOTS)));
        plan.push_back(known_row(MODE_ALLOC, 12'd0, ST_OK, 12'd0, 1'b0, 13'd4095));
        plan.push_back(known_row(MODE_ALLOC, 12'hfff, ST_OK, 12'd1, 1'b0, 13'd4094));
        plan.push_back(known_row(MODE_FREE, 12'd0, ST_OK, 12'd0, 1'b0, 13'd4095));
        plan.push_back(known_row(MODE_FREE, 12'd0, ST_DOUBLE_FREE, 12'd0, 1'b0, 13'd4095));
        plan.push_back(known_row(MODE_ALLOC, 12'd0, ST_OK, 12'd0, 1'b0, 13'd4094));
        plan.push_back(known_row(MODE_QUERY, 12'd1, ST_OK, 12'd0, 1'b0, 13'd4094));
        plan.push_back(known_row(MODE_SEEK, 12'hfff, ST_OK, 12'd0, 1'b0, 13'd4094));
        plan.push_back(known_row(MODE_ALLOC, 12'd0, ST_OK, 12'hfff, 1'b0, 13'd4093));
        // The hint now sits past the last slot and allocate does not wrap.
        plan.push_back(known_row(MODE_ALLOC, 12'd0, ST_NO_FREE, 12'd0, 1'b0, 13'd4093));
        plan.push_back(predicted_row(MODE_SEEK, 12'd0));
        plan.push_back(predicted_row(MODE_ALLOC, 12'h555));
        plan.push_back(known_row(MODE_SPARE5, 12'hfff, ST_OK, 12'd0, 1'b0, 13'd4092));
        plan.push_back(known_row(MODE_SPARE6, 12'haaa, ST_OK, 12'd0, 1'b0, 13'd4092));
        plan.push_back(known_row(MODE_SPARE7, 12'h555, ST_OK, 12'd0, 1'b0, 13'd4092));
        plan.push_back(known_row(MODE_CLEAR, 12'hfff, ST_OK, 12'd0, 1'b0, CNT_W'(MAX_SLOTS)));
        // A size of zero leaves no slots at all.
        plan.push_back(size_row(32'd0));
        plan.push_back(known_row(MODE_ALLOC, 12'd0, ST_NO_FREE, 12'd0, 1'b0, 13'd0));
        plan.push_back(known_row(MODE_FREE, 12'd0, ST_RANGE, 12'd0, 1'b0, 13'd0));
        plan.push_back(known_row(MODE_QUERY, 12'd0, ST_RANGE, 12'd0, 1'b0, 13'd0));
        plan.push_back(known_row(MODE_SEEK, 12'd7, ST_OK, 12'd0, 1'b0, 13'd0));
        // One slot: the count runs out, then the range check bites.
        plan.push_back(size_row(32'd1));
        plan.push_back(known_row(MODE_ALLOC, 12'd0, ST_OK, 12'd0, 1'b0, 13'd0));
        plan.push_back(known_row(MODE_ALLOC, 12'd0, ST_NO_FREE, 12'd0, 1'b0, 13'd0));
        plan.push_back(known_row(MODE_QUERY, 12'd1, ST_RANGE, 12'd0, 1'b0, 13'd0));
        plan.push_back(known_row(MODE_FREE, 12'd0, ST_OK, 12'd0, 1'b0, 13'd1));
        // Sizes above the capacity are clipped to it.
        plan.push_back(size_row(32'd8191));
        plan.push_back(known_row(MODE_QUERY, 12'hfff, ST_OK, 12'd0, 1'b1, CNT_W'(MAX_SLOTS)));

        phase_size = '{32'd4096, 32'hdead_0040, 32'd1, 32'd65, 32'd8191,
                       32'd130, 32'd4096, 32'd200, 32'd4095};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 20;
        rcv_idle_pct = 62;
        foreach (plan[i]) begin
            row = plan[i];
            if (row.kind == ROW_SIZE) begin
                wait_drained();
                write_size(row.size);
            end else begin
                send_request(row.mode, row.slot, row.kind == ROW_KNOWN, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_size(phase_size[p]);
            snd_idle_pct = (p < 3) ? 20 : (p < 6) ? 62 : 0;
            rcv_idle_pct = (p < 3) ? 62 : (p < 6) ? 20 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                if (p == HOLD_PHASE && n == 30) begin
                    hold_asks <= hold_asks + 1;
                end
                pick_request(mode, slot);
                send_request(mode, slot, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== bitmap_next_fit_allocator.f =====
rtl/bnfa_pkg.sv
rtl/bnfa_intf.sv
rtl/bnfa_ram.sv
rtl/bitmap_next_fit_allocator.sv
tb/sv/bitmap_next_fit_allocator_test.sv
